// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the reduction combiner.
// Depends on nothing; included by the files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define RCA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also holds during reset.
`define RCA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/rca_pkg.sv =====
// Package for the reduction combiner: widths, operation and type codes, helpers.
// Depends on nothing; imported by the interfaces and all RTL modules.
`timescale 1ns / 1ps

package rca_pkg;

    localparam int FIELD_W     = 64;
    localparam int HALF_W      = FIELD_W / 2;
    localparam int IDX_W       = 32;
    localparam int VALUE_WIDTH = 64;
    localparam int INDEX_WIDTH = 32;
    localparam int IDX_EFF_W   = (INDEX_WIDTH > IDX_W) ? IDX_W : INDEX_WIDTH;

    localparam int OP_W     = 4;
    localparam int TYPE_W   = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OP_SELECT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ELEM_TYPE = 1'd1;

    // Operations
    localparam logic [OP_W-1:0] OP_MAX    = 4'd0;
    localparam logic [OP_W-1:0] OP_MIN    = 4'd1;
    localparam logic [OP_W-1:0] OP_SUM    = 4'd2;
    localparam logic [OP_W-1:0] OP_PROD   = 4'd3;
    localparam logic [OP_W-1:0] OP_LAND   = 4'd4;
    localparam logic [OP_W-1:0] OP_LOR    = 4'd5;
    localparam logic [OP_W-1:0] OP_LXOR   = 4'd6;
    localparam logic [OP_W-1:0] OP_BAND   = 4'd7;
    localparam logic [OP_W-1:0] OP_BOR    = 4'd8;
    localparam logic [OP_W-1:0] OP_BXOR   = 4'd9;
    localparam logic [OP_W-1:0] OP_MAXLOC = 4'd10;
    localparam logic [OP_W-1:0] OP_MINLOC = 4'd11;

    localparam logic [OP_W-1:0]   OP_RESET   = OP_MAX;
    localparam logic [TYPE_W-1:0] TYPE_RESET = 3'd4;   // s32

    // Element size codes: elem_type[2:1]
    localparam logic [1:0] SZ_8  = 2'd0;
    localparam logic [1:0] SZ_16 = 2'd1;
    localparam logic [1:0] SZ_32 = 2'd2;
    localparam logic [1:0] SZ_64 = 2'd3;

    localparam logic [FIELD_W-1:0] VALUE_CAP = {FIELD_W{1'b1}} >> (FIELD_W - VALUE_WIDTH);

    typedef logic [FIELD_W-1:0]          value_t;
    typedef logic signed [IDX_EFF_W-1:0] idx_t;

    // Mask of the element bits, capped at VALUE_WIDTH.
    function automatic value_t elem_mask(input logic [TYPE_W-1:0] et);
        value_t m;
        unique case (et[2:1])
            SZ_8:    m = value_t'(8'hFF);
            SZ_16:   m = value_t'(16'hFFFF);
            SZ_32:   m = value_t'(32'hFFFF_FFFF);
            SZ_64:   m = {FIELD_W{1'b1}};
            default: m = {FIELD_W{1'b1}};
        endcase
        return m & VALUE_CAP;
    endfunction

    // Even type codes are two's complement.
    function automatic logic elem_signed(input logic [TYPE_W-1:0] et);
        return ~et[0];
    endfunction

endpackage

// ===== hw/rtl/rca_if.sv =====
// Stream interfaces for the reduction combiner: operand pairs in, results out.
// Depends on rca_pkg.
`timescale 1ns / 1ps

interface rca_in_if
    import rca_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [FIELD_W-1:0]   in_value;
    logic [FIELD_W-1:0]   acc_value;
    logic signed [IDX_W-1:0] in_index;
    logic signed [IDX_W-1:0] acc_index;
    logic                 last_in;

    modport source (output valid, in_value, acc_value, in_index, acc_index, last_in,
                    input ready);
    modport sink   (input valid, in_value, acc_value, in_index, acc_index, last_in,
                    output ready);
endinterface

interface rca_out_if
    import rca_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [FIELD_W-1:0]   result_value;
    logic signed [IDX_W-1:0] result_index;
    logic                 last_out;

    modport source (output valid, result_value, result_index, last_out, input ready);
    modport sink   (input valid, result_value, result_index, last_out, output ready);
endinterface

// ===== hw/rtl/rca_mul.sv =====
// Wrapping 64x64 multiplier built from three registered 32x32 partial products.
// Depends on rca_pkg; the product is valid after the enabled load that takes the operands.
`timescale 1ns / 1ps

module rca_mul
    import rca_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [FIELD_W-1:0] a,
    input  logic [FIELD_W-1:0] b,
    output logic [FIELD_W-1:0] product
);

    logic [FIELD_W-1:0] ll_reg;
    logic [HALF_W-1:0]  lh_reg;
    logic [HALF_W-1:0]  hl_reg;
    logic [FIELD_W-1:0] ll_next;
    logic [HALF_W-1:0]  lh_next;
    logic [HALF_W-1:0]  hl_next;
    logic [HALF_W-1:0]  cross_sum;

    // Only the low halves of the cross terms reach the wrapped product.
    always_comb
    begin
        ll_next = {{HALF_W{1'b0}}, a[HALF_W-1:0]} * {{HALF_W{1'b0}}, b[HALF_W-1:0]};
        lh_next = a[HALF_W-1:0] * b[FIELD_W-1:HALF_W];
        hl_next = a[FIELD_W-1:HALF_W] * b[HALF_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= ll_next;
            lh_reg <= lh_next;
            hl_reg <= hl_next;
        end
    end

    assign cross_sum = lh_reg + hl_reg;
    assign product   = ll_reg + {cross_sum, {HALF_W{1'b0}}};

endmodule

// ===== hw/rtl/mpi_reduction_combine_alu.sv =====
// Top level of the element-wise reduction combiner: three-stage pipeline.
// Depends on rca_pkg, rca_if, rca_mul and assert_macros.svh.
//
//   channel | direction | carries
//   --------+-----------+-------------------------------------------------
//   req     | in        | in_value, acc_value, in_index, acc_index, last_in
//   rsp     | out       | result_value, result_index, last_out
//   cfg_*   | in        | register writes (op_select, elem_type)
//
// One item per cycle while rsp is not stalled; each input is registered in stages 1, 2
// and 3 in turn before its result is offered at rsp.
// Stage 1 masks operands, stage 2 compares, adds and forms partial products,
// stage 3 selects the result into the output register.
// A stall at rsp holds a full stage 3 and each full stage whose successor is held; others keep filling.
// Reset empties the pipeline and sets op_select to max, elem_type to s32.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mpi_reduction_combine_alu
    import rca_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    rca_in_if.sink                req,
    rca_out_if.source             rsp
);

    // Configuration
    logic [OP_W-1:0]   op_reg;
    logic [TYPE_W-1:0] type_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg   <= OP_RESET;
            type_reg <= TYPE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OP_SELECT: op_reg   <= cfg_wdata[OP_W-1:0];
                REG_ELEM_TYPE: type_reg <= cfg_wdata[TYPE_W-1:0];
                default:       ;
            endcase
        end
    end

    value_t mask;
    value_t sbit;
    assign mask = elem_mask(type_reg);
    assign sbit = elem_signed(type_reg) ? (mask & ~(mask >> 1)) : '0;

    // Stage advance: a stage loads when empty or when its successor moves on
    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2, adv3;
    assign adv3 = !v3_reg || rsp.ready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign req.ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= req.valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    // Stage 1: masked operands and order keys
    value_t a1_reg, b1_reg, ka1_reg, kb1_reg;
    idx_t   ai1_reg, bi1_reg;
    logic   last1_reg;

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            a1_reg    <= req.in_value & mask;
            b1_reg    <= req.acc_value & mask;
            ka1_reg   <= (req.in_value & mask) ^ sbit;
            kb1_reg   <= (req.acc_value & mask) ^ sbit;
            ai1_reg   <= req.in_index[IDX_EFF_W-1:0];
            bi1_reg   <= req.acc_index[IDX_EFF_W-1:0];
            last1_reg <= req.last_in;
        end
    end

    // Stage 2: compares, sum, partial products
    value_t a2_reg, b2_reg, sum2_reg;
    logic   gt2_reg, lt2_reg, eq2_reg, bidx_lo2_reg;
    idx_t   ai2_reg, bi2_reg;
    logic   last2_reg;

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            a2_reg       <= a1_reg;
            b2_reg       <= b1_reg;
            sum2_reg     <= a1_reg + b1_reg;
            gt2_reg      <= ka1_reg > kb1_reg;
            lt2_reg      <= ka1_reg < kb1_reg;
            eq2_reg      <= ka1_reg == kb1_reg;
            bidx_lo2_reg <= bi1_reg < ai1_reg;
            ai2_reg      <= ai1_reg;
            bi2_reg      <= bi1_reg;
            last2_reg    <= last1_reg;
        end
    end

    value_t prod2;
    rca_mul u_mul (
        .clk     (clk),
        .en      (adv2),
        .a       (a1_reg),
        .b       (b1_reg),
        .product (prod2)
    );

    // Stage 3: result select
    value_t r_next;
    idx_t   ri_next;
    logic   az, bz;
    assign az = (a2_reg == '0);
    assign bz = (b2_reg == '0);

    always_comb
    begin
        r_next  = b2_reg;
        ri_next = bi2_reg;
        unique case (op_reg)
            OP_MAX:  r_next = lt2_reg ? b2_reg : a2_reg;
            OP_MIN:  r_next = gt2_reg ? b2_reg : a2_reg;
            OP_SUM:  r_next = sum2_reg;
            OP_PROD: r_next = prod2;
            OP_LAND: r_next = value_t'(!az && !bz);
            OP_LOR:  r_next = value_t'(!az || !bz);
            OP_LXOR: r_next = value_t'(az != bz);
            OP_BAND: r_next = a2_reg & b2_reg;
            OP_BOR:  r_next = a2_reg | b2_reg;
            OP_BXOR: r_next = a2_reg ^ b2_reg;
            OP_MAXLOC, OP_MINLOC:
            begin
                if ((op_reg == OP_MAXLOC) ? gt2_reg : lt2_reg)
                begin
                    r_next  = a2_reg;
                    ri_next = ai2_reg;
                end
                else if (eq2_reg)
                begin
                    // tie: keep the smaller index
                    ri_next = bidx_lo2_reg ? bi2_reg : ai2_reg;
                end
            end
            default: ;  // accumulator passes through
        endcase
    end

    value_t r3_reg;
    idx_t   ri3_reg;
    logic   last3_reg;

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            r3_reg    <= r_next & mask;
            ri3_reg   <= ri_next;
            last3_reg <= last2_reg;
        end
    end

    assign rsp.valid        = v3_reg;
    assign rsp.result_value = r3_reg;
    assign rsp.result_index = IDX_W'(ri3_reg);
    assign rsp.last_out     = last3_reg;

    `RCA_ASSERT(a_s1_hold, clk, rst_n, v1_reg && !adv2 |=> v1_reg,
                "stage 1 item dropped during stall")
    `RCA_ASSERT(a_s2_hold, clk, rst_n, v2_reg && !adv3 |=> v2_reg && $stable(sum2_reg),
                "stage 2 item lost or changed during stall")
    `RCA_ASSERT(a_width, clk, rst_n, rsp.valid |-> ((rsp.result_value & ~mask) == '0),
                "result has bits above element width")
    `RCA_ASSERT(a_logic, clk, rst_n,
                rsp.valid && (op_reg == OP_LAND || op_reg == OP_LOR || op_reg == OP_LXOR)
                |-> (rsp.result_value >> 1) == '0,
                "logical result is not 0 or 1")

endmodule
